// ===== design/ashs_pkg.sv =====
// Package: sizes, register indexes, controller states, command types and constant tables.
`timescale 1ns / 1ps
`default_nettype none
package ashs_pkg;

  localparam int MAX_HARM   = 64;
  localparam int H_W        = $clog2(MAX_HARM);
  localparam int SINE_DEPTH = 1024;
  localparam int SINE_IW    = $clog2(SINE_DEPTH);
  localparam int SINE_AW    = SINE_IW + 1;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [2:0] {
    REG_PHASE_STEP   = 3'd0,
    REG_HARM_LIMIT   = 3'd1,
    REG_PARTIAL_RATIO = 3'd2,
    REG_VOLUME_GAIN  = 3'd3,
    REG_SAMPLE_TOTAL = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_WRITE,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic rd;
    logic calc;
    logic wr;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last_h;
    logic out_free;
  } sts_t;

  typedef logic [14:0] sine_rom_t [0:SINE_DEPTH];
  typedef logic [14:0] amp_rom_t  [0:MAX_HARM-1];

  // Quarter-wave sine in Q1.15, integer Taylor series, rounded.
  function automatic sine_rom_t build_sine();
    sine_rom_t rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] q;
    logic signed [63:0] sum;
    for (int i = 0; i <= SINE_DEPTH; i++) begin
      x   = (HALF_PI_Q30 * 64'(i)) >> SINE_IW;
      x2  = (x * x) >> 30;
      sum = $signed(x);
      t = ((x * x2) >> 30) / 64'd6;    sum = sum - $signed(t);
      t = ((t * x2) >> 30) / 64'd20;   sum = sum + $signed(t);
      t = ((t * x2) >> 30) / 64'd42;   sum = sum - $signed(t);
      t = ((t * x2) >> 30) / 64'd72;   sum = sum + $signed(t);
      t = ((t * x2) >> 30) / 64'd110;  sum = sum - $signed(t);
      t = ((t * x2) >> 30) / 64'd156;  sum = sum + $signed(t);
      t = ((t * x2) >> 30) / 64'd210;  sum = sum - $signed(t);
      if (sum < 0) begin
        q = 64'd0;
      end else begin
        q = (64'(sum) + 64'd16384) >> 15;
      end
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
      rom[i] = q[14:0];
    end
    return rom;
  endfunction

  // Harmonic amplitude trunc(32767/h) by restoring long division; entry zero unused.
  function automatic amp_rom_t build_amp();
    amp_rom_t rom;
    logic [14:0] q;
    logic [29:0] r;
    rom[0] = 15'd0;
    for (int i = 1; i < MAX_HARM; i++) begin
      r = 30'd32767;
      q = '0;
      for (int b = 14; b >= 0; b--) begin
        if (r >= (30'(i) << b)) begin
          r    = r - (30'(i) << b);
          q[b] = 1'b1;
        end
      end
      rom[i] = q;
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();
  localparam amp_rom_t  AMP_ROM  = build_amp();

endpackage
`default_nettype wire

// ===== design/ashs_if.sv =====
// Interfaces: input, result and configuration channels.
`timescale 1ns / 1ps
`default_nettype none
interface ashs_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface ashs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample;
  logic        last;
  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface ashs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== design/ashs_ram.sv =====
// Generic single-write, single-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module ashs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/ashs_ctrl.sv =====
// Controller: sequences the harmonic loop for one sample.
`timescale 1ns / 1ps
`default_nettype none
module ashs_ctrl import ashs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_CALC;
      ST_CALC:   state_nxt = ST_WRITE;
      ST_WRITE:  state_nxt = sts.last_h ? ST_DRAIN1 : ST_READ;
      ST_DRAIN1: state_nxt = ST_DRAIN2;
      ST_DRAIN2: state_nxt = ST_OUT;
      ST_OUT:    if (sts.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    cmd       = '0;
    cmd.start = (state_r == ST_IDLE) && in_valid;
    cmd.rd    = (state_r == ST_READ);
    cmd.calc  = (state_r == ST_CALC);
    cmd.wr    = (state_r == ST_WRITE);
    cmd.emit  = (state_r == ST_OUT) && sts.out_free;
  end
endmodule
`default_nettype wire

// ===== design/ashs_dp.sv =====
// Datapath: registers, phase store, increment and term arithmetic, result register.
`timescale 1ns / 1ps
`default_nettype none
module ashs_dp import ashs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic        restart,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_sample,
  output logic             out_last
);
  logic [31:0] step_r, ratio_r;
  logic [6:0]  limit_r;
  logic signed [15:0] gain_r;
  logic [23:0] total_r, pos_r;

  logic [H_W-1:0] h_r;
  logic [H_W-1:0] hidx;
  logic [MAX_HARM-1:0] valid_r;
  logic [31:0] power_r;
  logic [63:0] m1_r;
  logic [31:0] ph_r, inc_r;
  logic [14:0] rom_r;
  logic        neg_r;
  logic signed [31:0] p1_r, p2_r;
  logic        pa_v_r, pb_v_r;
  logic [15:0] acc_r;
  logic        last_r;
  logic        out_valid_r;
  logic [15:0] out_sample_r;
  logic        out_last_r;

  logic [31:0] ram_q, ph_cur;
  logic [1:0]  quad;
  logic [SINE_IW-1:0] idx;
  logic [SINE_AW-1:0] j;
  logic [63:0] m2;
  logic [37:0] incp;
  logic signed [15:0] amp_s, sine_s;
  logic signed [15:0] t1;
  logic signed [17:0] t2;
  logic [23:0] pos_base;
  logic [24:0] pos_inc;
  logic [23:0] total_eff;
  logic        last_nxt;

  assign cfg_ready = 1'b1;
  assign hidx = h_r - H_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      limit_r <= 7'd2;
      ratio_r <= 32'd1073741824;
      gain_r  <= 16'sd16384;
      total_r <= 24'd44100;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PHASE_STEP:    step_r  <= cfg_data;
        REG_HARM_LIMIT:    limit_r <= cfg_data[6:0];
        REG_PARTIAL_RATIO: ratio_r <= cfg_data;
        REG_VOLUME_GAIN:   gain_r  <= $signed(cfg_data[15:0]);
        REG_SAMPLE_TOTAL:  total_r <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  ashs_ram #(.WIDTH(32), .DEPTH(MAX_HARM)) u_phase (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (hidx),
    .wdata (ph_r + inc_r),
    .raddr (hidx),
    .rdata (ram_q)
  );

  // Note position and last flag.
  always_comb begin
    pos_base  = restart ? 24'd0 : pos_r;
    pos_inc   = {1'b0, pos_base} + 25'd1;
    total_eff = (total_r == 24'd0) ? 24'd1 : total_r;
    last_nxt  = pos_inc >= {1'b0, total_eff};
  end

  always_comb begin
    ph_cur = valid_r[hidx] ? ram_q : 32'd0;
    quad   = ph_cur[31:30];
    idx    = ph_cur[29 -: SINE_IW];
    j      = quad[0] ? SINE_AW'(SINE_DEPTH) - {1'b0, idx} : {1'b0, idx};
    m2     = 64'(power_r) * 64'(ratio_r);
    incp   = 38'(m1_r[61:30]) * 38'(h_r);
    amp_s  = h_r[0] ? -$signed({1'b0, AMP_ROM[h_r]}) : $signed({1'b0, AMP_ROM[h_r]});
    sine_s = neg_r ? -$signed({1'b0, rom_r}) : $signed({1'b0, rom_r});
    t1     = 16'((p1_r >>> 15) + ((p1_r < 0 && p1_r[14:0] != '0) ? 32'sd1 : 32'sd0));
    t2     = 18'((p2_r >>> 14) + ((p2_r < 0 && p2_r[13:0] != '0) ? 32'sd1 : 32'sd0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      pos_r   <= '0;
      pa_v_r  <= 1'b0;
      pb_v_r  <= 1'b0;
      h_r     <= H_W'(1);
    end else begin
      pa_v_r <= cmd.wr && ({1'b0, h_r} < limit_r);
      pb_v_r <= pa_v_r;
      if (cmd.start) begin
        pos_r <= last_nxt ? 24'd0 : pos_inc[23:0];
        h_r   <= H_W'(1);
        if (restart) begin
          valid_r <= '0;
        end
      end
      if (cmd.wr) begin
        valid_r[hidx] <= 1'b1;
        h_r <= h_r + H_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      power_r <= 32'd1073741824;
      last_r  <= last_nxt;
    end
    if (cmd.rd) begin
      m1_r <= 64'(step_r) * 64'(power_r);
    end
    if (cmd.calc) begin
      ph_r  <= ph_cur;
      inc_r <= incp[31:0];
      rom_r <= SINE_ROM[j];
      neg_r <= quad[1];
      power_r <= (m2[63:62] != 2'b00) ? 32'hFFFF_FFFF : m2[61:30];
    end
    if (cmd.wr) begin
      p1_r <= 32'(amp_s) * 32'(sine_s);
    end
    p2_r <= 32'(t1) * 32'(gain_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.start) begin
      acc_r <= '0;
    end else if (pb_v_r) begin
      acc_r <= acc_r + t2[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sample_r <= acc_r;
      out_last_r   <= last_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_sample   = out_sample_r;
  assign out_last     = out_last_r;
  assign sts.last_h   = (h_r == H_W'(MAX_HARM - 1));
  assign sts.out_free = !out_valid_r || out_ready;

  a_wr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> h_r != '0) else $error("phase write with harmonic zero");
  a_restart_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start && restart) |=> valid_r == '0) else $error("restart left phases");
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> acc_r == '0) else $error("accumulator not cleared");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready)) else $error("result overwritten");
endmodule
`default_nettype wire

// ===== design/additive_saw_harmonic_synth.sv =====
// Top level: additive sawtooth synthesiser, controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none
//  channel    dir  payload                      item
//  in_chan    in   restart (1)                  one sample request
//  out_chan   out  sample (16 s), last (1)      one audio sample
//  cfg_chan   in   index (3), data (32)         one register write
//
//  Each sample runs ST_READ, ST_CALC and ST_WRITE for harmonics 1..63
//  (phase RAM read, increment and sine lookup, phase write-back), then the
//  drain states empty the term multipliers and ST_OUT loads the result register.
//  Reset clears the phase valid bits at once; no clearing pass is needed.
//  A waiting result holds in the output register while the next item is taken;
//  the loop stalls at its end only if that register is still full.
module additive_saw_harmonic_synth import ashs_pkg::*; (
  input wire logic   clk,
  input wire logic   rst_n,
  ashs_in_if.sink    in_chan,
  ashs_out_if.source out_chan,
  ashs_cfg_if.sink   cfg_chan
);
  cmd_t cmd;
  sts_t sts;

  // Sequence the harmonic loop.
  ashs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold registers, phases and arithmetic.
  ashs_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .restart    (in_chan.restart),
    .cfg_valid  (cfg_chan.valid),
    .cfg_ready  (cfg_chan.ready),
    .cfg_index  (cfg_chan.index),
    .cfg_data   (cfg_chan.data),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_sample (out_chan.sample),
    .out_last   (out_chan.last)
  );
endmodule
`default_nettype wire

// ===== bench/ashs_checker.sv =====
// Checker: watches the three channels, predicts each audio sample and compares.
`timescale 1ns / 1ps
`default_nettype none
module ashs_checker import ashs_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  ashs_in_if       in_mon,
  ashs_out_if      out_mon,
  ashs_cfg_if      cfg_mon,
  output int       fail_count,
  output int       pending
);

  typedef struct {
    logic [15:0] sample;
    logic        last;
  } audio_t;

  logic [15:0] quarter_sine [0:SINE_DEPTH];

  logic [31:0] step_q32;
  logic [6:0]  harm_limit;
  logic [31:0] ratio_q30;
  logic [15:0] gain_q14;
  logic [23:0] note_len;
  logic [31:0] phase_acc [0:MAX_HARM-1];
  logic [23:0] note_pos;

  audio_t expected_audio [$];

  // Rebuild the quarter-wave table by integer Taylor series, rounded to Q1.15.
  initial begin
    logic [63:0] x, x2, t, q;
    logic signed [63:0] sum;
    for (int i = 0; i <= SINE_DEPTH; i++) begin
      x   = (64'd1686629713 * 64'(i)) / 64'(SINE_DEPTH);
      x2  = (x * x) >> 30;
      t   = x;
      sum = $signed(x);
      for (int k = 1; k <= 7; k++) begin
        t = (t * x2) >> 30;
        t = t / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum = sum - $signed(t);
        else sum = sum + $signed(t);
      end
      if (sum < 0) sum = 0;
      q = (64'(sum) + 64'd16384) >> 15;
      if (q > 64'd32767) q = 64'd32767;
      quarter_sine[i] = q[15:0];
    end
  end

  function automatic int signed sine_at(logic [31:0] ph);
    logic [63:0] idx;
    int          j;
    int signed   v;
    idx = (64'(ph[29:0]) * 64'(SINE_DEPTH)) >> 30;
    j   = ph[30] ? SINE_DEPTH - int'(idx) : int'(idx);
    if (j > SINE_DEPTH) j = SINE_DEPTH;
    v = int'(quarter_sine[j]);
    return ph[31] ? -v : v;
  endfunction

  // Form one sample and advance every partial, as the block does per item.
  function automatic audio_t synth_sample(logic restart);
    audio_t      res;
    int          lim;
    logic [63:0] pw, inc;
    int signed   amp, t1, t2, gain;
    logic [15:0] acc;
    logic [23:0] len;
    acc  = 16'd0;
    pw   = 64'd1 << 30;
    gain = int'($signed(gain_q14));
    len  = (note_len == 0) ? 24'd1 : note_len;
    lim  = (int'(harm_limit) > MAX_HARM) ? MAX_HARM : int'(harm_limit);
    if (restart) begin
      for (int h = 0; h < MAX_HARM; h++) phase_acc[h] = 32'd0;
      note_pos = 24'd0;
    end
    for (int h = 1; h < MAX_HARM; h++) begin
      if (h < lim) begin
        amp = 32767 / h;
        if (h % 2 == 1) amp = -amp;
        t1  = (amp * sine_at(phase_acc[h-1])) / 32768;
        t2  = (t1 * gain) / 16384;
        acc = acc + t2[15:0];
      end
      inc = ((64'(step_q32) * pw) >> 30) * 64'(h);
      phase_acc[h-1] = phase_acc[h-1] + inc[31:0];
      pw = (pw * 64'(ratio_q30)) >> 30;
      if (pw > 64'hFFFF_FFFF) pw = 64'hFFFF_FFFF;
    end
    res.sample = acc;
    res.last   = (25'(note_pos) + 25'd1 >= 25'(len));
    note_pos   = res.last ? 24'd0 : note_pos + 24'd1;
    return res;
  endfunction

  always @(posedge clk) begin
    audio_t want;
    int     errs;
    errs = 0;
    if (!rst_n) begin
      step_q32   <= 32'd0;
      harm_limit <= 7'd2;
      ratio_q30  <= 32'd1073741824;
      gain_q14   <= 16'd16384;
      note_len   <= 24'd44100;
      note_pos   <= 24'd0;
      for (int h = 0; h < MAX_HARM; h++) phase_acc[h] <= 32'd0;
      expected_audio.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (reg_idx_t'(cfg_mon.index))
          REG_PHASE_STEP:    step_q32   <= cfg_mon.data;
          REG_HARM_LIMIT:    harm_limit <= cfg_mon.data[6:0];
          REG_PARTIAL_RATIO: ratio_q30  <= cfg_mon.data;
          REG_VOLUME_GAIN:   gain_q14   <= cfg_mon.data[15:0];
          REG_SAMPLE_TOTAL:  note_len   <= cfg_mon.data[23:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_audio.size() == 0) begin
          $error("unexpected sample %h", out_mon.sample);
          errs++;
        end else begin
          want = expected_audio.pop_front();
          if (out_mon.sample !== want.sample) begin
            $error("sample: expected %h, got %h", want.sample, out_mon.sample);
            errs++;
          end
          if (out_mon.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_mon.last);
            errs++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_audio.push_back(synth_sample(in_mon.restart));
      end
      if (errs != 0) begin
        fail_count <= fail_count + errs;
      end
      pending <= expected_audio.size();
    end
  end

endmodule
`default_nettype wire

// ===== bench/tb_additive_saw_harmonic_synth.sv =====
// Testbench top: stimulus, back-pressure and verdict for the additive sawtooth synthesiser.
`timescale 1ns / 1ps
`default_nettype none
module tb_additive_saw_harmonic_synth;
  import ashs_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  bit   calm;          // when set, neither side idles
  int   out_hold;

  ashs_in_if  in_chan ();
  ashs_out_if out_chan ();
  ashs_cfg_if cfg_chan ();

  additive_saw_harmonic_synth u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  ashs_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .cfg_mon    (cfg_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // Generous ceiling: many times what 2000 samples with full gaps would need.
  initial begin
    #40ms;
    $display("tb_additive_saw_harmonic_synth NOT OK");
    $finish;
  end

  // Result side: after each accepted sample, drop ready for a random hold unless calm is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      out_hold       <= 0;
    end else if (out_chan.valid && out_chan.ready) begin
      out_hold       <= calm ? 0 : $urandom_range(10);
      out_chan.ready <= calm;
    end else if (out_hold > 0) begin
      out_hold       <= out_hold - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // Write one register; the channel is only used while the block is idle.
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= value;
    do @(posedge clk); while (!cfg_chan.ready);
  endtask

  // Wait for every expected sample, then let the loop settle.
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic load_regs(logic [31:0] step, logic [6:0] lim, logic [31:0] ratio,
                           logic [15:0] gain, logic [23:0] len);
    drain();
    write_reg(REG_PHASE_STEP, step);
    write_reg(REG_HARM_LIMIT, {25'($urandom), lim});
    write_reg(REG_PARTIAL_RATIO, ratio);
    write_reg(REG_VOLUME_GAIN, {16'($urandom), gain});
    write_reg(REG_SAMPLE_TOTAL, {8'($urandom), len});
    cfg_chan.valid <= 1'b0;
  endtask

  // Offer one sample request after a random gap; keep valid high when the gap is zero.
  task automatic request(logic restart);
    int gap;
    gap = calm ? 0 : $urandom_range(10);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.restart <= restart;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic run_notes(int n);
    for (int i = 0; i < n; i++) request($urandom_range(24) == 0);
  endtask

  initial begin
    logic [31:0] step, ratio;
    logic [6:0]  lim;
    logic [23:0] len;
    calm            = 1'b0;
    in_chan.valid   = 1'b0;
    in_chan.restart = 1'b0;
    cfg_chan.valid  = 1'b0;
    cfg_chan.index  = REG_PHASE_STEP;
    cfg_chan.data   = 32'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: step zero, one harmonic, so a flat zero signal.
    request(1'b0);
    request(1'b1);

    // Directed: extremes of every register, restart both ways, every limit corner.
    load_regs(32'h0100_0000, 7'd64, 32'h4000_0000, 16'h7FFF, 24'd3);
    request(1'b0); request(1'b0); request(1'b1); request(1'b0);
    load_regs(32'hFFFF_FFFF, 7'd127, 32'hFFFF_FFFF, 16'h8000, 24'd1);
    request(1'b0); request(1'b0); request(1'b1);
    load_regs(32'h0123_4567, 7'd0, 32'd0, 16'h4000, 24'd0);
    request(1'b0); request(1'b0);
    load_regs(32'h0123_4567, 7'd1, 32'h4100_0000, 16'hC000, 24'hFF_FFFF);
    request(1'b0); request(1'b0);
    load_regs(32'h0080_0000, 7'd63, 32'h3F00_0000, 16'h7FFF, 24'd2);
    request(1'b1); request(1'b0); request(1'b0); request(1'b0);
    load_regs(32'h0004_0000, 7'd2, 32'h8000_0000, 16'h8000, 24'd5);
    request(1'b0); request(1'b0); request(1'b0);

    // Random phases: mostly short notes and near-harmonic ratios, some wild settings.
    for (int p = 0; p < 40; p++) begin
      step  = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0400_0000);
      lim   = ($urandom_range(7) == 0) ? 7'($urandom) : 7'($urandom_range(64));
      ratio = ($urandom_range(3) == 0) ? $urandom
                                       : 32'h4000_0000 + $urandom_range(32'h0100_0000)
                                         - 32'h0080_0000;
      len   = ($urandom_range(5) == 0) ? 24'($urandom) : 24'($urandom_range(40));
      load_regs(step, lim, ratio, 16'($urandom), len);
      calm = (p % 5 == 2);
      run_notes(25);
      if (p == 7) begin
        // Hold the sender until every sample has come back, then carry on.
        in_chan.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      run_notes(25);
      calm = 1'b0;
    end

    drain();
    if (fail_count == 0) begin
      $display("tb_additive_saw_harmonic_synth OK");
    end else begin
      $display("tb_additive_saw_harmonic_synth NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
